FILE: sv/wlm_pkg.sv
// Shared types and constants of the wildcard LIKE matcher.
`default_nettype none

package wlm_pkg;

  localparam int PATTERN_DEPTH = 32;
  localparam int SYM_W         = 16;
  localparam int CNT_W         = $clog2(PATTERN_DEPTH + 1);
  localparam int CFG_IDX_W     = 1;

  localparam logic [SYM_W-1:0] ANY_SEQ_RESET = SYM_W'(37);
  localparam logic [SYM_W-1:0] ANY_ONE_RESET = SYM_W'(95);

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_APPEND  = 2'd1,
    CMD_SUBJECT = 2'd2,
    CMD_END     = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ANY_SEQ = 1'b0,
    CFG_ANY_ONE = 1'b1
  } cfg_idx_t;

  // per-cell control from the top level
  typedef struct packed {
    logic in_use;
    logic load;
    logic step;
    logic restart;
  } cell_ctl_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflowed;
  } result_t;

endpackage

`default_nettype wire

FILE: sv/wlm_ifs.sv
// Handshake channel interfaces of the wildcard LIKE matcher.
`default_nettype none

interface wlm_item_if;
  logic                        valid;
  logic                        ready;
  wlm_pkg::cmd_t               command;
  logic [wlm_pkg::SYM_W-1:0]   symbol;
  modport source (output valid, command, symbol, input ready);
  modport sink   (input valid, command, symbol, output ready);
endinterface

interface wlm_result_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_overflowed;
  modport source (output valid, matched, pattern_overflowed, input ready);
  modport sink   (input valid, matched, pattern_overflowed, output ready);
endinterface

interface wlm_cfg_if;
  logic                          valid;
  logic                          ready;
  wlm_pkg::cfg_idx_t             index;
  logic [wlm_pkg::SYM_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: sv/wildcard_like_matcher.sv
// Top level of the streaming SQL LIKE wildcard matcher.
`default_nettype none

// Matches a streamed subject string against a pattern held in a row of
// PATTERN_DEPTH cells (32). Items on the item channel are commands: clear the
// pattern, append one pattern character, feed one subject character, or end
// the subject. Only the end command produces a transfer on the result
// channel: matched, plus the sticky pattern_overflowed flag (set when an
// append found the store full, cleared by a clear). Any append, clear or end
// restarts matching. Each cell holds one pattern character and one active bit
// of the position automaton; a subject character updates all cells in the
// same cycle, with empty-run spreading over any-sequence wildcards rippling
// cell to cell like a carry chain. Throughput is one item per cycle on every
// command while the result queue has room. A result enters the result queue
// when its end item is taken. It is a two-entry queue, so the item channel
// keeps taking items while one result waits and stalls only while two wait.
// The wildcard codes live in two registers written on the cfg channel
// (index 0 any-sequence, reset 37 '%'; index 1 any-one, reset 95 '_'); when
// both hold the same code it acts as any-sequence. cfg.ready is always high.
module wildcard_like_matcher (
  input  wire logic     clk,
  input  wire logic     rst,
  wlm_item_if.sink      item,
  wlm_result_if.source  result,
  wlm_cfg_if.sink       cfg
);
  import wlm_pkg::*;

  // configuration registers
  logic [SYM_W-1:0] any_seq;
  logic [SYM_W-1:0] any_one;

  // pattern bookkeeping
  logic [CNT_W-1:0] count;
  logic             overflow_seen;
  logic             active_end;   // position past the last cell

  // cell chain links; index i feeds cell i from cell i-1
  logic [PATTERN_DEPTH:0]   reach;
  logic [PATTERN_DEPTH:0]   adv;
  logic [PATTERN_DEPTH:0]   closed_all;
  cell_ctl_t                ctl [PATTERN_DEPTH];

  logic    fire;
  logic    do_clear;
  logic    do_append;
  logic    do_step;
  logic    do_end;
  logic    store_full;
  logic    queue_full;
  logic    hit;
  result_t res;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      any_seq <= ANY_SEQ_RESET;
      any_one <= ANY_ONE_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_ANY_SEQ: any_seq <= cfg.data;
        CFG_ANY_ONE: any_one <= cfg.data;
        default:     ;
      endcase
    end
  end

  // input handshake: only a full result queue holds items back
  assign item.ready = !queue_full;
  assign fire       = item.valid & item.ready;
  assign do_clear   = fire && (item.command == CMD_CLEAR);
  assign do_append  = fire && (item.command == CMD_APPEND);
  assign do_step    = fire && (item.command == CMD_SUBJECT);
  assign do_end     = fire && (item.command == CMD_END);
  assign store_full = (count == CNT_W'(PATTERN_DEPTH));

  assign reach[0] = 1'b0;
  assign adv[0]   = 1'b0;

  for (genvar i = 0; i < PATTERN_DEPTH; i++) begin : g_cell
    always_comb begin
      ctl[i].in_use  = (CNT_W'(i) < count);
      ctl[i].load    = do_append && (count == CNT_W'(i));
      ctl[i].step    = do_step;
      ctl[i].restart = do_clear | do_append | do_end;
    end

    wlm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .head      (i == 0),
      .ctl       (ctl[i]),
      .symbol    (item.symbol),
      .seq_char  (any_seq),
      .one_char  (any_one),
      .reach_in  (reach[i]),
      .adv_in    (adv[i]),
      .reach_out (reach[i+1]),
      .adv_out   (adv[i+1]),
      .closed    (closed_all[i])
    );
  end

  assign closed_all[PATTERN_DEPTH] = active_end | reach[PATTERN_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      overflow_seen <= 1'b0;
      active_end    <= 1'b0;
    end else begin
      if (do_clear) begin
        count         <= '0;
        overflow_seen <= 1'b0;
      end else if (do_append) begin
        if (store_full) begin
          overflow_seen <= 1'b1;
        end else begin
          count <= count + CNT_W'(1);
        end
      end
      if (do_clear || do_append || do_end) begin
        active_end <= 1'b0;
      end else if (do_step) begin
        active_end <= adv[PATTERN_DEPTH];
      end
    end
  end

  // an empty pattern matches everything; otherwise the closed position at count
  assign hit                    = (count == '0) | closed_all[count];
  assign res.matched            = hit;
  assign res.pattern_overflowed = overflow_seen;

  wlm_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (do_end),
    .push_data (res),
    .full      (queue_full),
    .result    (result)
  );

  a_count_range: assert property (@(posedge clk) disable iff (rst)
      count <= CNT_W'(PATTERN_DEPTH))
    else $error("wildcard_like_matcher: pattern count out of range");
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
      overflow_seen |-> store_full)
    else $error("wildcard_like_matcher: overflow flag with room left");
  a_clear: assert property (@(posedge clk) disable iff (rst)
      do_clear |=> (count == '0) && !overflow_seen)
    else $error("wildcard_like_matcher: clear did not empty the pattern");
  a_end_result: assert property (@(posedge clk) disable iff (rst)
      do_end |=> result.valid)
    else $error("wildcard_like_matcher: end item produced no result");
  a_end_pos: assert property (@(posedge clk) disable iff (rst)
      (active_end && !store_full) |-> 1'b0)
    else $error("wildcard_like_matcher: final position active on short pattern");

endmodule

`default_nettype wire

FILE: sv/wlm_cell.sv
// One pattern position: stored character, active bit and its link to the neighbor.
`default_nettype none

module wlm_cell (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      head,
  input  wire wlm_pkg::cell_ctl_t        ctl,
  input  wire logic [wlm_pkg::SYM_W-1:0] symbol,
  input  wire logic [wlm_pkg::SYM_W-1:0] seq_char,
  input  wire logic [wlm_pkg::SYM_W-1:0] one_char,
  input  wire logic                      reach_in,
  input  wire logic                      adv_in,
  output logic                           reach_out,
  output logic                           adv_out,
  output logic                           closed
);
  import wlm_pkg::*;

  logic             active;
  logic             active_next;
  logic [SYM_W-1:0] pat;
  logic             is_seq;

  always_comb begin
    // empty-run spread arrives from the left neighbor
    closed      = active | reach_in;
    is_seq      = (pat == seq_char);
    reach_out   = closed & ctl.in_use & is_seq;
    adv_out     = closed & ctl.in_use & !is_seq & ((pat == symbol) || (pat == one_char));
    active_next = adv_in | reach_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= head;
    end else if (ctl.restart) begin
      active <= head;
    end else if (ctl.step) begin
      active <= active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      pat <= symbol;
    end
  end

endmodule

`default_nettype wire

FILE: sv/wlm_out_buf.sv
// Two-entry result queue in front of the result channel.
`default_nettype none

module wlm_out_buf (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire wlm_pkg::result_t push_data,
  output logic                full,
  wlm_result_if.source        result
);
  import wlm_pkg::*;

  logic    valid0;
  logic    valid1;
  result_t data0;
  result_t data1;
  logic    pop;

  assign pop                       = valid0 & result.ready;
  assign full                      = valid1;
  assign result.valid              = valid0;
  assign result.matched            = data0.matched;
  assign result.pattern_overflowed = data0.pattern_overflowed;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid0 <= 1'b0;
      valid1 <= 1'b0;
    end else begin
      // idle cycles fall through with everything held
      if (pop && push) begin
        if (valid1) begin
          data0 <= data1;
          data1 <= push_data;
        end else begin
          data0 <= push_data;
        end
      end else if (pop) begin
        data0  <= data1;
        valid0 <= valid1;
        valid1 <= 1'b0;
      end else if (push) begin
        if (!valid0) begin
          data0  <= push_data;
          valid0 <= 1'b1;
        end else begin
          data1  <= push_data;
          valid1 <= 1'b1;
        end
      end
    end
  end

  // second slot is only used behind a waiting head entry
  a_slot_order: assert property (@(posedge clk) disable iff (rst) valid1 |-> valid0)
    else $error("wlm_out_buf: second slot valid without head");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("wlm_out_buf: push into full queue");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
      (valid0 && !result.ready) |=> valid0 && $stable(data0))
    else $error("wlm_out_buf: head entry changed while stalled");

endmodule

`default_nettype wire
